@@ src/lifo_pkg.sv @@
// lifo_pkg: shared types and constants for the lifo stack with palindrome flag
// depends on nothing; imported by lifo_stack_with_palindrome_check
package lifo_pkg;

	localparam int DEPTH      = 8;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = 4;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TOP,
		S_SCAN,
		S_DONE
	} state_t;

	// where the result word comes from
	typedef enum logic [1:0] {
		SRC_MEM,
		SRC_WORD,
		SRC_ZERO
	} src_t;

	typedef struct packed {
		logic [1:0]               op;
		logic signed [DATA_WIDTH-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_WIDTH-1:0] data_value;
		logic [CNT_W-1:0]         entry_count;
		logic                     is_full;
		logic                     is_empty;
		logic                     is_palindrome;
	} rsp_t;

endpackage

@@ src/lifo_stack_with_palindrome_check.sv @@
// lifo_stack_with_palindrome_check: bounded lifo stack held in a dual-read ram,
// with a palindrome flag from a pairwise scan. depends on lifo_pkg
//
// channel   dir  handshake                 payload
// request   in   start high, busy low      req   (op, push_value)
// result    out  done high for one cycle   rsp   (status, data_value, entry_count,
//                                                 is_full, is_empty, is_palindrome)
//
// after accept the top word is taken, then the scan reads one mirrored pair per cycle
// over the two ram read ports, floor(n/2) pairs in all, n being the entry count after
// the update; depth thus bounds the scan.
// busy drops in the done cycle, so a new request may be taken there.
// reset clears the control and the count; ram contents are never cleared.
// results cannot be stalled: each is shown for exactly one cycle.
module lifo_stack_with_palindrome_check (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lifo_pkg::req_t req,
	output logic           done,
	output lifo_pkg::rsp_t rsp
);
	import lifo_pkg::*;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_a_q, rd_b_q;
	logic [ADDR_W-1:0]     addr_a, addr_b;

	state_t state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [1:0]            status_q, status_d;
	src_t                  src_q, src_d;
	logic [DATA_WIDTH-1:0] word_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [ADDR_W-1:0]     lo_q, hi_q;
	logic                  pal_q;
	logic                  cmp_v_s1;
	logic                  accept, wr_en, issue;

	assign accept = start && !busy;
	assign issue  = (state_q == S_TOP || state_q == S_SCAN) && (lo_q < hi_q);

	// new count, status and data source for the incoming request
	always_comb begin
		count_d  = count_q;
		status_d = ST_OK;
		src_d    = SRC_MEM;
		wr_en    = 1'b0;
		unique case (req.op)
			OP_PUSH: begin
				if (count_q == CNT_W'(DEPTH)) begin
					status_d = ST_OVERFLOW;
				end else begin
					count_d = count_q + 1'b1;
					src_d   = SRC_WORD;
					wr_en   = accept;
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					status_d = ST_UNDERFLOW;
					src_d    = SRC_ZERO;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				if (count_q == '0) begin
					status_d = ST_UNDERFLOW;
					src_d    = SRC_ZERO;
				end
			end
		endcase
	end

	// port a reads the old top while idle, then the low side of each pair
	always_comb begin
		if (state_q == S_TOP || state_q == S_SCAN) begin
			addr_a = lo_q;
		end else begin
			addr_a = ADDR_W'(count_q - 1'b1);
		end
		addr_b = hi_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[ADDR_W-1:0]] <= req.push_value;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cmp_v_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			cmp_v_s1 <= issue;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			src_q    <= src_d;
			word_q   <= req.push_value;
			lo_q     <= '0;
			hi_q     <= (count_d == '0) ? '0 : ADDR_W'(count_d - 1'b1);
			pal_q    <= (count_d != '0);
		end else begin
			if (issue) begin
				lo_q <= lo_q + 1'b1;
				hi_q <= hi_q - 1'b1;
			end
			if (cmp_v_s1 && rd_a_q != rd_b_q) begin
				pal_q <= 1'b0;
			end
		end
		if (state_q == S_TOP) begin
			case (src_q)
				SRC_WORD: data_q <= word_q;
				SRC_ZERO: data_q <= '0;
				default:  data_q <= rd_a_q;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = S_TOP;
				end
			end
			S_TOP: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (lo_q >= hi_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				busy    = 1'b0;
				done    = 1'b1;
				state_d = start ? S_TOP : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp.status        = status_q;
		rsp.data_value    = data_q;
		rsp.entry_count   = count_q;
		rsp.is_full       = (count_q == CNT_W'(DEPTH));
		rsp.is_empty      = (count_q == '0);
		rsp.is_palindrome = pal_q;
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_pal_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.is_empty |-> !rsp.is_palindrome)
		else $error("palindrome flag set on empty stack");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_OVERFLOW |-> rsp.is_full)
		else $error("overflow reported while not full");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_UNDERFLOW |-> rsp.is_empty && rsp.data_value == '0)
		else $error("underflow reported with entries or data");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted request did not start work");
`endif

endmodule
